FILE: design/ctc_pkg.sv
// ctc_pkg: shared types, constants and saturating fixed-point helpers for the
// computed torque controller; no dependencies
package ctc_pkg;

  localparam int FX_W         = 32;
  localparam int FRAC         = 16;
  localparam int CFG_W        = 31;
  localparam int ADDR_W       = 5;
  localparam int CORDIC_STEPS = 30;
  localparam int RED_STEPS    = 14;
  localparam int RED_W        = 47;
  localparam int TURN_W       = 33;
  localparam int Z_W          = 34;
  localparam int TRIG_W       = 20;
  localparam int TRIG_LAT     = RED_STEPS + CORDIC_STEPS + 4;
  localparam int DYN_STAGES   = 9;

  typedef logic signed [FX_W-1:0] fx_t;
  typedef logic [RED_W-1:0] red_t;
  typedef logic [TURN_W-1:0] turn_t;
  typedef logic signed [Z_W-1:0] z_t;
  typedef logic signed [TRIG_W-1:0] trig_val_t;

  localparam fx_t FX_MAX = 32'sh7fffffff;
  localparam fx_t FX_MIN = 32'sh80000000;
  localparam turn_t TWO_PI_Q30 = 33'd6746518852;
  localparam z_t PI_Q30 = 34'sd3373259426;
  localparam z_t HALF_PI_Q30 = 34'sd1686629713;
  localparam z_t CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam red_t RED_OFFSET = red_t'(TWO_PI_Q30) << (RED_STEPS - 1);

  typedef enum logic [2:0] {
    REG_L1, REG_L2, REG_M1, REG_M2, REG_G, REG_KP, REG_KV
  } reg_idx_t;

  localparam logic [CFG_W-1:0] RST_L1 = 31'd131072;
  localparam logic [CFG_W-1:0] RST_L2 = 31'd131072;
  localparam logic [CFG_W-1:0] RST_M1 = 31'd65536;
  localparam logic [CFG_W-1:0] RST_M2 = 31'd65536;
  localparam logic [CFG_W-1:0] RST_G  = 31'd642908;
  localparam logic [CFG_W-1:0] RST_KP = 31'd32768;
  localparam logic [CFG_W-1:0] RST_KV = 31'd65536;

  typedef struct packed {
    logic sat;
    fx_t  val;
  } fxs_t;

  typedef struct packed {
    logic [CFG_W-1:0] l1;
    logic [CFG_W-1:0] l2;
    logic [CFG_W-1:0] m1;
    logic [CFG_W-1:0] m2;
    logic [CFG_W-1:0] g;
    logic [CFG_W-1:0] kp;
    logic [CFG_W-1:0] kv;
  } cfg_t;

  typedef struct packed {
    fxs_t e1;
    fxs_t e2;
    fxs_t ev1;
    fxs_t ev2;
    fxs_t x3;
    fxs_t x4;
    fxs_t qa1;
    fxs_t qa2;
  } pay_t;

  typedef struct packed {
    trig_val_t cs1;
    trig_val_t cs2;
    trig_val_t cs12;
    trig_val_t sn2;
  } trig_t;

  typedef struct packed {
    fx_t  t1;
    fx_t  t2;
    fx_t  e1;
    fx_t  e2;
    logic sat;
  } res_t;

  typedef struct packed {
    logic flip;
    z_t   z;
  } fold_t;

  function automatic fxs_t mk(fx_t v);
    fxs_t r;
    r.sat = 1'b0;
    r.val = v;
    return r;
  endfunction

  function automatic fxs_t reg_fx(logic [CFG_W-1:0] v);
    return mk($signed({1'b0, v}));
  endfunction

  function automatic fxs_t sat64(logic signed [63:0] v, logic sat_in);
    fxs_t r;
    if (v > 64'(FX_MAX)) begin
      r.sat = 1'b1;
      r.val = FX_MAX;
    end else if (v < 64'(FX_MIN)) begin
      r.sat = 1'b1;
      r.val = FX_MIN;
    end else begin
      r.sat = sat_in;
      r.val = v[FX_W-1:0];
    end
    r.sat = r.sat | sat_in;
    return r;
  endfunction

  function automatic fxs_t fadd(fxs_t a, fxs_t b);
    logic signed [FX_W:0] s;
    s = (FX_W+1)'(a.val) + (FX_W+1)'(b.val);
    return sat64(64'(s), a.sat | b.sat);
  endfunction

  function automatic fxs_t fsub(fxs_t a, fxs_t b);
    logic signed [FX_W:0] s;
    s = (FX_W+1)'(a.val) - (FX_W+1)'(b.val);
    return sat64(64'(s), a.sat | b.sat);
  endfunction

  function automatic fxs_t fmul(fxs_t a, fxs_t b);
    logic signed [63:0] p;
    p = 64'(a.val) * 64'(b.val);
    return sat64(p >>> FRAC, a.sat | b.sat);
  endfunction

  function automatic fold_t fold(turn_t r);
    fold_t f;
    z_t    v;
    v = $signed({1'b0, r});
    if (v >= PI_Q30) v = v - $signed({1'b0, TWO_PI_Q30});
    f.flip = 1'b0;
    if (v > HALF_PI_Q30) begin
      v = v - PI_Q30;
      f.flip = 1'b1;
    end else if (v < -HALF_PI_Q30) begin
      v = v + PI_Q30;
      f.flip = 1'b1;
    end
    f.z = v;
    return f;
  endfunction

  function automatic z_t atan_q30(int i);
    case (i)
      0: return 34'sd843314857;
      1: return 34'sd497837830;
      2: return 34'sd263043837;
      3: return 34'sd133525159;
      4: return 34'sd67021687;
      5: return 34'sd33543516;
      6: return 34'sd16775851;
      7: return 34'sd8388437;
      8: return 34'sd4194283;
      9: return 34'sd2097149;
      default: return z_t'(64'sd1 <<< (30 - i));
    endcase
  endfunction

endpackage

FILE: design/ctc_cordic.sv
// ctc_cordic: one rotation cordic lane, one step per register stage, then sign
// flip and rescale; depends on ctc_pkg
module ctc_cordic (
  input  logic               clk,
  input  ctc_pkg::z_t        z_in,
  input  logic               flip_in,
  output ctc_pkg::trig_val_t cos_val,
  output ctc_pkg::trig_val_t sin_val
);

  localparam int N = ctc_pkg::CORDIC_STEPS;

  ctc_pkg::z_t cx [0:N];
  ctc_pkg::z_t cy [0:N];
  ctc_pkg::z_t cz [0:N];
  logic        cf [0:N];

  assign cx[0] = ctc_pkg::CORDIC_GAIN_Q30;
  assign cy[0] = '0;
  assign cz[0] = z_in;
  assign cf[0] = flip_in;

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam ctc_pkg::z_t Atan = ctc_pkg::atan_q30(i);
    always_ff @(posedge clk) begin
      if (cz[i] >= 0) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - Atan;
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + Atan;
      end
      cf[i+1] <= cf[i];
    end
  end

  ctc_pkg::z_t xf;
  ctc_pkg::z_t yf;

  assign xf = cf[N] ? -cx[N] : cx[N];
  assign yf = cf[N] ? -cy[N] : cy[N];

  always_ff @(posedge clk) begin
    cos_val <= ctc_pkg::TRIG_W'(xf >>> (30 - ctc_pkg::FRAC));
    sin_val <= ctc_pkg::TRIG_W'(yf >>> (30 - ctc_pkg::FRAC));
  end

endmodule

FILE: design/ctc_trig.sv
// ctc_trig: angle reduction modulo two pi, folding, and three cordic lanes
// for joint 1, joint 2 and their sum; depends on ctc_pkg and ctc_cordic
module ctc_trig (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  ctc_pkg::fx_t   angle1,
  input  ctc_pkg::fx_t   angle2,
  output logic           out_valid,
  output ctc_pkg::trig_t trig
);

  localparam int RED = ctc_pkg::RED_STEPS;
  localparam int LAT = ctc_pkg::TRIG_LAT;

  ctc_pkg::red_t  u1 [0:RED];
  ctc_pkg::red_t  u2 [0:RED];
  ctc_pkg::turn_t r1;
  ctc_pkg::turn_t r2;
  ctc_pkg::turn_t r12;
  logic [ctc_pkg::TURN_W:0] rsum;
  ctc_pkg::fold_t f1;
  ctc_pkg::fold_t f2;
  ctc_pkg::fold_t f12;
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    u1[0] <= {{(ctc_pkg::RED_W-ctc_pkg::FX_W){angle1[ctc_pkg::FX_W-1]}}, angle1}
             * (ctc_pkg::red_t'(1) << (30 - ctc_pkg::FRAC)) + ctc_pkg::RED_OFFSET;
    u2[0] <= {{(ctc_pkg::RED_W-ctc_pkg::FX_W){angle2[ctc_pkg::FX_W-1]}}, angle2}
             * (ctc_pkg::red_t'(1) << (30 - ctc_pkg::FRAC)) + ctc_pkg::RED_OFFSET;
  end

  for (genvar s = 1; s <= RED; s++) begin : g_red
    localparam ctc_pkg::red_t Step = ctc_pkg::red_t'(ctc_pkg::TWO_PI_Q30) << (RED - s);
    always_ff @(posedge clk) begin
      u1[s] <= (u1[s-1] >= Step) ? u1[s-1] - Step : u1[s-1];
      u2[s] <= (u2[s-1] >= Step) ? u2[s-1] - Step : u2[s-1];
    end
  end

  assign rsum = {1'b0, u1[RED][ctc_pkg::TURN_W-1:0]} + {1'b0, u2[RED][ctc_pkg::TURN_W-1:0]};

  always_ff @(posedge clk) begin
    r1  <= u1[RED][ctc_pkg::TURN_W-1:0];
    r2  <= u2[RED][ctc_pkg::TURN_W-1:0];
    r12 <= (rsum >= {1'b0, ctc_pkg::TWO_PI_Q30}) ?
           ctc_pkg::TURN_W'(rsum - {1'b0, ctc_pkg::TWO_PI_Q30}) :
           ctc_pkg::TURN_W'(rsum);
    f1  <= ctc_pkg::fold(r1);
    f2  <= ctc_pkg::fold(r2);
    f12 <= ctc_pkg::fold(r12);
  end

  ctc_cordic u_lane1 (
    .clk(clk), .z_in(f1.z), .flip_in(f1.flip), .cos_val(trig.cs1), .sin_val()
  );

  ctc_cordic u_lane2 (
    .clk(clk), .z_in(f2.z), .flip_in(f2.flip), .cos_val(trig.cs2), .sin_val(trig.sn2)
  );

  ctc_cordic u_lane12 (
    .clk(clk), .z_in(f12.z), .flip_in(f12.flip), .cos_val(trig.cs12), .sin_val()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[LAT-1];

endmodule

FILE: design/ctc_dynamics.sv
// ctc_dynamics: pipelined pd law, mass matrix, coriolis and gravity terms and
// torque sums with saturation; depends on ctc_pkg
module ctc_dynamics (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  ctc_pkg::trig_t trig,
  input  ctc_pkg::pay_t  pay,
  input  ctc_pkg::cfg_t  cfg,
  output logic           out_valid,
  output ctc_pkg::res_t  res
);

  typedef ctc_pkg::fxs_t f_t;

  typedef struct packed {
    f_t l2l2, l1l2, l1l1, msum, mg2, x34, x44, x33;
    f_t kve1, kve2, kpe1, kpe2, qa1, qa2, e1, e2;
    f_t cs1, cs2, cs12, sn2;
  } st1_t;

  typedef struct packed {
    f_t m22, k, msl11, msg, mg2l2, v2, a1, a2, x44, x33, kpe1, kpe2, e1, e2;
    f_t cs1, cs2, cs12, sn2;
  } st2_t;

  typedef struct packed {
    f_t kc, v, kx33, msgl1, gt2, s1, s2, m22, msl11, k, e1, e2, sn2, cs1;
  } st3_t;

  typedef struct packed {
    f_t m12, m11a, kc2, kv, n2a, g1, s1, s2, m22, gt2, e1, e2, sn2;
  } st4_t;

  typedef struct packed {
    f_t m11, kvs, n2, m12, m22, s1, s2, g1, gt2, e1, e2;
  } st5_t;

  typedef struct packed {
    f_t n1a, p11, p12, p21, p22, n2, g1, gt2, e1, e2;
  } st6_t;

  typedef struct packed {
    f_t n1b, t1a, t2a, n2, gt2, e1, e2;
  } st7_t;

  typedef struct packed {
    f_t n1, t2, t1a, e1, e2;
  } st8_t;

  f_t l1, l2, m1, m2, g, kp, kv;
  st1_t s1;
  st2_t s2;
  st3_t s3;
  st4_t s4;
  st5_t s5;
  st6_t s6;
  st7_t s7;
  st8_t s8;
  f_t   t1_f;
  f_t   t2_f;
  logic [ctc_pkg::DYN_STAGES-1:0] vld;

  assign l1 = ctc_pkg::reg_fx(cfg.l1);
  assign l2 = ctc_pkg::reg_fx(cfg.l2);
  assign m1 = ctc_pkg::reg_fx(cfg.m1);
  assign m2 = ctc_pkg::reg_fx(cfg.m2);
  assign g  = ctc_pkg::reg_fx(cfg.g);
  assign kp = ctc_pkg::reg_fx(cfg.kp);
  assign kv = ctc_pkg::reg_fx(cfg.kv);

  always_ff @(posedge clk) begin
    s1.l2l2 <= ctc_pkg::fmul(l2, l2);
    s1.l1l2 <= ctc_pkg::fmul(l1, l2);
    s1.l1l1 <= ctc_pkg::fmul(l1, l1);
    s1.msum <= ctc_pkg::fadd(m1, m2);
    s1.mg2  <= ctc_pkg::fmul(m2, g);
    s1.x34  <= ctc_pkg::fmul(pay.x3, pay.x4);
    s1.x44  <= ctc_pkg::fmul(pay.x4, pay.x4);
    s1.x33  <= ctc_pkg::fmul(pay.x3, pay.x3);
    s1.kve1 <= ctc_pkg::fmul(kv, pay.ev1);
    s1.kve2 <= ctc_pkg::fmul(kv, pay.ev2);
    s1.kpe1 <= ctc_pkg::fmul(kp, pay.e1);
    s1.kpe2 <= ctc_pkg::fmul(kp, pay.e2);
    s1.qa1  <= pay.qa1;
    s1.qa2  <= pay.qa2;
    s1.e1   <= pay.e1;
    s1.e2   <= pay.e2;
    s1.cs1  <= ctc_pkg::mk(ctc_pkg::fx_t'(trig.cs1));
    s1.cs2  <= ctc_pkg::mk(ctc_pkg::fx_t'(trig.cs2));
    s1.cs12 <= ctc_pkg::mk(ctc_pkg::fx_t'(trig.cs12));
    s1.sn2  <= ctc_pkg::mk(ctc_pkg::fx_t'(trig.sn2));
  end

  always_ff @(posedge clk) begin
    s2.m22   <= ctc_pkg::fmul(m2, s1.l2l2);
    s2.k     <= ctc_pkg::fmul(m2, s1.l1l2);
    s2.msl11 <= ctc_pkg::fmul(s1.msum, s1.l1l1);
    s2.msg   <= ctc_pkg::fmul(s1.msum, g);
    s2.mg2l2 <= ctc_pkg::fmul(s1.mg2, l2);
    s2.v2    <= ctc_pkg::fadd(s1.x34, s1.x34);
    s2.a1    <= ctc_pkg::fadd(s1.qa1, s1.kve1);
    s2.a2    <= ctc_pkg::fadd(s1.qa2, s1.kve2);
    s2.x44   <= s1.x44;
    s2.x33   <= s1.x33;
    s2.kpe1  <= s1.kpe1;
    s2.kpe2  <= s1.kpe2;
    s2.e1    <= s1.e1;
    s2.e2    <= s1.e2;
    s2.cs1   <= s1.cs1;
    s2.cs2   <= s1.cs2;
    s2.cs12  <= s1.cs12;
    s2.sn2   <= s1.sn2;
  end

  always_ff @(posedge clk) begin
    s3.kc    <= ctc_pkg::fmul(s2.k, s2.cs2);
    s3.v     <= ctc_pkg::fadd(s2.v2, s2.x44);
    s3.kx33  <= ctc_pkg::fmul(s2.k, s2.x33);
    s3.msgl1 <= ctc_pkg::fmul(s2.msg, l1);
    s3.gt2   <= ctc_pkg::fmul(s2.mg2l2, s2.cs12);
    s3.s1    <= ctc_pkg::fadd(s2.a1, s2.kpe1);
    s3.s2    <= ctc_pkg::fadd(s2.a2, s2.kpe2);
    s3.m22   <= s2.m22;
    s3.msl11 <= s2.msl11;
    s3.k     <= s2.k;
    s3.e1    <= s2.e1;
    s3.e2    <= s2.e2;
    s3.sn2   <= s2.sn2;
    s3.cs1   <= s2.cs1;
  end

  always_ff @(posedge clk) begin
    s4.m12  <= ctc_pkg::fadd(s3.m22, s3.kc);
    s4.m11a <= ctc_pkg::fadd(s3.msl11, s3.m22);
    s4.kc2  <= ctc_pkg::fadd(s3.kc, s3.kc);
    s4.kv   <= ctc_pkg::fmul(s3.k, s3.v);
    s4.n2a  <= ctc_pkg::fmul(s3.kx33, s3.sn2);
    s4.g1   <= ctc_pkg::fmul(s3.msgl1, s3.cs1);
    s4.s1   <= s3.s1;
    s4.s2   <= s3.s2;
    s4.m22  <= s3.m22;
    s4.gt2  <= s3.gt2;
    s4.e1   <= s3.e1;
    s4.e2   <= s3.e2;
    s4.sn2  <= s3.sn2;
  end

  always_ff @(posedge clk) begin
    s5.m11 <= ctc_pkg::fadd(s4.m11a, s4.kc2);
    s5.kvs <= ctc_pkg::fmul(s4.kv, s4.sn2);
    s5.n2  <= ctc_pkg::fadd(s4.n2a, s4.gt2);
    s5.m12 <= s4.m12;
    s5.m22 <= s4.m22;
    s5.s1  <= s4.s1;
    s5.s2  <= s4.s2;
    s5.g1  <= s4.g1;
    s5.gt2 <= s4.gt2;
    s5.e1  <= s4.e1;
    s5.e2  <= s4.e2;
  end

  always_ff @(posedge clk) begin
    s6.n1a <= ctc_pkg::fsub(ctc_pkg::mk('0), s5.kvs);
    s6.p11 <= ctc_pkg::fmul(s5.m11, s5.s1);
    s6.p12 <= ctc_pkg::fmul(s5.m12, s5.s2);
    s6.p21 <= ctc_pkg::fmul(s5.m12, s5.s1);
    s6.p22 <= ctc_pkg::fmul(s5.m22, s5.s2);
    s6.n2  <= s5.n2;
    s6.g1  <= s5.g1;
    s6.gt2 <= s5.gt2;
    s6.e1  <= s5.e1;
    s6.e2  <= s5.e2;
  end

  always_ff @(posedge clk) begin
    s7.n1b <= ctc_pkg::fadd(s6.n1a, s6.g1);
    s7.t1a <= ctc_pkg::fadd(s6.p11, s6.p12);
    s7.t2a <= ctc_pkg::fadd(s6.p21, s6.p22);
    s7.n2  <= s6.n2;
    s7.gt2 <= s6.gt2;
    s7.e1  <= s6.e1;
    s7.e2  <= s6.e2;
  end

  always_ff @(posedge clk) begin
    s8.n1  <= ctc_pkg::fadd(s7.n1b, s7.gt2);
    s8.t2  <= ctc_pkg::fadd(s7.t2a, s7.n2);
    s8.t1a <= s7.t1a;
    s8.e1  <= s7.e1;
    s8.e2  <= s7.e2;
  end

  assign t1_f = ctc_pkg::fadd(s8.t1a, s8.n1);
  assign t2_f = s8.t2;

  always_ff @(posedge clk) begin
    res.t1  <= t1_f.val;
    res.t2  <= t2_f.val;
    res.e1  <= s8.e1.val;
    res.e2  <= s8.e2.val;
    res.sat <= t1_f.sat | t2_f.sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ctc_pkg::DYN_STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld[ctc_pkg::DYN_STAGES-1];

endmodule

FILE: design/computed_torque_controller_core.sv
// computed_torque_controller_core: top level with register port, input stage,
// error front end and delay line; depends on ctc_pkg, ctc_trig, ctc_dynamics
//
// Takes one sample word in every clock cycle (busy stays low) and shows its
// result word on the output ports, with done high for one cycle. The word
// passes the input registers, the angle reduction (14 steps) and the 30-step
// cordic, one step per stage, then nine stages of multiply and saturating add
// for the dynamics. Results cannot be held off by the receiver. The user must
// write registers only while no sample is in flight; the block itself does
// not enforce this.
module computed_torque_controller_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ctc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [31:0]         angle1_meas,
  input  logic signed [31:0]         angle2_meas,
  input  logic signed [31:0]         speed1_meas,
  input  logic signed [31:0]         speed2_meas,
  input  logic signed [31:0]         angle1_target,
  input  logic signed [31:0]         angle2_target,
  input  logic signed [31:0]         speed1_target,
  input  logic signed [31:0]         speed2_target,
  input  logic signed [31:0]         accel1_target,
  input  logic signed [31:0]         accel2_target,
  output logic                       done,
  output logic signed [31:0]         torque_joint1,
  output logic signed [31:0]         torque_joint2,
  output logic signed [31:0]         angle1_error,
  output logic signed [31:0]         angle2_error,
  output logic                       saturated
);

  localparam int LAT = ctc_pkg::TRIG_LAT;

  ctc_pkg::cfg_t    cfg;
  ctc_pkg::reg_idx_t widx;
  logic             wr;
  logic             in_vld;
  ctc_pkg::fx_t     x1, x2, x3, x4, qd1, qd2, qv1, qv2, qa1, qa2;
  ctc_pkg::pay_t    front;
  ctc_pkg::pay_t    dly [0:LAT-1];
  logic             trig_vld;
  ctc_pkg::trig_t   trig;
  ctc_pkg::res_t    res;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign widx   = ctc_pkg::reg_idx_t'(paddr[ctc_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.l1 <= ctc_pkg::RST_L1;
      cfg.l2 <= ctc_pkg::RST_L2;
      cfg.m1 <= ctc_pkg::RST_M1;
      cfg.m2 <= ctc_pkg::RST_M2;
      cfg.g  <= ctc_pkg::RST_G;
      cfg.kp <= ctc_pkg::RST_KP;
      cfg.kv <= ctc_pkg::RST_KV;
    end else if (wr) begin
      case (widx)
        ctc_pkg::REG_L1: cfg.l1 <= pwdata[ctc_pkg::CFG_W-1:0];
        ctc_pkg::REG_L2: cfg.l2 <= pwdata[ctc_pkg::CFG_W-1:0];
        ctc_pkg::REG_M1: cfg.m1 <= pwdata[ctc_pkg::CFG_W-1:0];
        ctc_pkg::REG_M2: cfg.m2 <= pwdata[ctc_pkg::CFG_W-1:0];
        ctc_pkg::REG_G:  cfg.g  <= pwdata[ctc_pkg::CFG_W-1:0];
        ctc_pkg::REG_KP: cfg.kp <= pwdata[ctc_pkg::CFG_W-1:0];
        ctc_pkg::REG_KV: cfg.kv <= pwdata[ctc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      ctc_pkg::REG_L1: prdata = {1'b0, cfg.l1};
      ctc_pkg::REG_L2: prdata = {1'b0, cfg.l2};
      ctc_pkg::REG_M1: prdata = {1'b0, cfg.m1};
      ctc_pkg::REG_M2: prdata = {1'b0, cfg.m2};
      ctc_pkg::REG_G:  prdata = {1'b0, cfg.g};
      ctc_pkg::REG_KP: prdata = {1'b0, cfg.kp};
      ctc_pkg::REG_KV: prdata = {1'b0, cfg.kv};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      x1  <= angle1_meas;
      x2  <= angle2_meas;
      x3  <= speed1_meas;
      x4  <= speed2_meas;
      qd1 <= angle1_target;
      qd2 <= angle2_target;
      qv1 <= speed1_target;
      qv2 <= speed2_target;
      qa1 <= accel1_target;
      qa2 <= accel2_target;
    end
  end

  always_comb begin
    front.e1  = ctc_pkg::fsub(ctc_pkg::mk(qd1), ctc_pkg::mk(x1));
    front.e2  = ctc_pkg::fsub(ctc_pkg::mk(qd2), ctc_pkg::mk(x2));
    front.ev1 = ctc_pkg::fsub(ctc_pkg::mk(qv1), ctc_pkg::mk(x3));
    front.ev2 = ctc_pkg::fsub(ctc_pkg::mk(qv2), ctc_pkg::mk(x4));
    front.x3  = ctc_pkg::mk(x3);
    front.x4  = ctc_pkg::mk(x4);
    front.qa1 = ctc_pkg::mk(qa1);
    front.qa2 = ctc_pkg::mk(qa2);
  end

  always_ff @(posedge clk) begin
    dly[0] <= front;
  end

  for (genvar i = 1; i < LAT; i++) begin : g_dly
    always_ff @(posedge clk) begin
      dly[i] <= dly[i-1];
    end
  end

  ctc_trig u_trig (
    .clk(clk), .rst(rst), .in_valid(in_vld), .angle1(x1), .angle2(x2),
    .out_valid(trig_vld), .trig(trig)
  );

  ctc_dynamics u_dyn (
    .clk(clk), .rst(rst), .in_valid(trig_vld), .trig(trig), .pay(dly[LAT-1]),
    .cfg(cfg), .out_valid(done), .res(res)
  );

  assign torque_joint1 = res.t1;
  assign torque_joint2 = res.t2;
  assign angle1_error  = res.e1;
  assign angle2_error  = res.e2;
  assign saturated     = res.sat;

endmodule

FILE: design/ctc_checker.sv
// ctc_checker: port-level checks on latency and register writes, bound to
// the top level; depends on ctc_pkg
module ctc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [ctc_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                pwdata,
  input logic [31:0]                prdata,
  input logic                       pready,
  input logic                       start,
  input logic                       busy,
  input logic                       done
);

  localparam int LAT = ctc_pkg::TRIG_LAT + ctc_pkg::DYN_STAGES + 1;

  a_lat: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("accepted word gave no result");

  a_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without accepted word");

  a_wr: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready &&
    paddr[ctc_pkg::ADDR_W-1:2] <= 3'(ctc_pkg::REG_KV)
    |=> (paddr != $past(paddr)) || (prdata == {1'b0, $past(pwdata[30:0])}))
    else $error("register readback mismatch");

endmodule

bind computed_torque_controller_core ctc_checker u_chk (.*);

FILE: dv/tb_computed_torque_controller_core.sv
// tb_computed_torque_controller_core: self-checking bench for the two-link computed torque
// core; drives sample words and apb register writes, predicts every result word
// depends on ctc_pkg and computed_torque_controller_core
module tb_computed_torque_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FULL_TURN = 64'sd6746518852;
  localparam longint HALF_TURN = 64'sd3373259426;
  localparam longint QUARTER_TURN = 64'sd1686629713;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint TOP = 64'sd2147483647;
  localparam longint BOTTOM = -64'sd2147483648;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN = 80;

  typedef struct {
    ctc_pkg::fx_t t1;
    ctc_pkg::fx_t t2;
    ctc_pkg::fx_t e1;
    ctc_pkg::fx_t e2;
    logic sat;
  } torque_word_t;

  typedef struct {
    ctc_pkg::fx_t v[10];
    bit chk;
    ctc_pkg::fx_t e1;
    ctc_pkg::fx_t e2;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ctc_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  ctc_pkg::fx_t a1m = '0, a2m = '0, s1m = '0, s2m = '0, a1t = '0, a2t = '0;
  ctc_pkg::fx_t s1t = '0, s2t = '0, c1t = '0, c2t = '0;
  logic done;
  ctc_pkg::fx_t torque_joint1, torque_joint2, angle1_error, angle2_error;
  logic saturated;

  computed_torque_controller_core u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .angle1_meas(a1m), .angle2_meas(a2m), .speed1_meas(s1m), .speed2_meas(s2m),
    .angle1_target(a1t), .angle2_target(a2t), .speed1_target(s1t),
    .speed2_target(s2t), .accel1_target(c1t), .accel2_target(c2t),
    .done(done), .torque_joint1(torque_joint1), .torque_joint2(torque_joint2),
    .angle1_error(angle1_error), .angle2_error(angle2_error), .saturated(saturated)
  );

  always #1 clk = ~clk;

  longint gains [7];
  bit clip_seen;
  torque_word_t pending_torques[$];
  int mismatches = 0;
  int idle_cycles = 0;
  vector_t vectors[$];

  function automatic longint clip(longint v);
    if (v > TOP) begin
      clip_seen = 1'b1;
      return TOP;
    end
    if (v < BOTTOM) begin
      clip_seen = 1'b1;
      return BOTTOM;
    end
    return v;
  endfunction

  function automatic longint qadd(longint a, longint b);
    return clip(a + b);
  endfunction

  function automatic longint qsub(longint a, longint b);
    return clip(a - b);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clip((a * b) >>> ctc_pkg::FRAC);
  endfunction

  function automatic longint wrap_angle(longint a);
    longint whole, part, r;
    whole = a >>> ctc_pkg::FRAC;
    part = a & 64'hffff;
    r = whole % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    for (int k = 0; k < 30; k++) r = (r * 2) % FULL_TURN;
    return (r + (part <<< (30 - ctc_pkg::FRAC))) % FULL_TURN;
  endfunction

  function automatic longint arctan_step(int i);
    longint steps [11] = '{843314857, 497837830, 263043837, 133525159, 67021687,
                           33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
    return i < 11 ? steps[i] : (64'sd1 <<< (30 - i));
  endfunction

  task automatic rotate(input longint turn, output longint sn, output longint cs);
    longint x, y, z, dx, dy, r;
    bit flip;
    x = GAIN_Q30;
    y = 0;
    r = turn;
    flip = 1'b0;
    if (r >= HALF_TURN) r -= FULL_TURN;
    if (r > QUARTER_TURN) begin
      r -= HALF_TURN;
      flip = 1'b1;
    end else if (r < -QUARTER_TURN) begin
      r += HALF_TURN;
      flip = 1'b1;
    end
    z = r;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cs = x >>> (30 - ctc_pkg::FRAC);
    sn = y >>> (30 - ctc_pkg::FRAC);
  endtask

  task automatic torque_law(input ctc_pkg::fx_t v[10], output torque_word_t w);
    longint x1, x2, x3, x4, e1, e2, ev1, ev2, r1, r2, sn1, cs1, sn2, cs2, sn12, cs12;
    longint msum, k, kc, m11, m12, m22, vv, n1, n2, gt2, sa, sb, t1, t2;
    x1 = v[0]; x2 = v[1]; x3 = v[2]; x4 = v[3];
    clip_seen = 1'b0;
    e1 = qsub(v[4], x1);
    e2 = qsub(v[5], x2);
    ev1 = qsub(v[6], x3);
    ev2 = qsub(v[7], x4);
    r1 = wrap_angle(x1);
    r2 = wrap_angle(x2);
    rotate(r2, sn2, cs2);
    rotate(r1, sn1, cs1);
    rotate((r1 + r2) % FULL_TURN, sn12, cs12);
    msum = qadd(gains[ctc_pkg::REG_M1], gains[ctc_pkg::REG_M2]);
    m22 = qmul(gains[ctc_pkg::REG_M2],
               qmul(gains[ctc_pkg::REG_L2], gains[ctc_pkg::REG_L2]));
    k = qmul(gains[ctc_pkg::REG_M2],
             qmul(gains[ctc_pkg::REG_L1], gains[ctc_pkg::REG_L2]));
    kc = qmul(k, cs2);
    m12 = qadd(m22, kc);
    m11 = qadd(qadd(qmul(msum, qmul(gains[ctc_pkg::REG_L1], gains[ctc_pkg::REG_L1])),
                    m22), qadd(kc, kc));
    vv = qmul(x3, x4);
    vv = qadd(qadd(vv, vv), qmul(x4, x4));
    n1 = qsub(0, qmul(qmul(k, vv), sn2));
    n1 = qadd(n1, qmul(qmul(qmul(msum, gains[ctc_pkg::REG_G]),
                            gains[ctc_pkg::REG_L1]), cs1));
    gt2 = qmul(qmul(qmul(gains[ctc_pkg::REG_M2], gains[ctc_pkg::REG_G]),
                    gains[ctc_pkg::REG_L2]), cs12);
    n1 = qadd(n1, gt2);
    n2 = qadd(qmul(qmul(k, qmul(x3, x3)), sn2), gt2);
    sa = qadd(qadd(v[8], qmul(gains[ctc_pkg::REG_KV], ev1)),
              qmul(gains[ctc_pkg::REG_KP], e1));
    sb = qadd(qadd(v[9], qmul(gains[ctc_pkg::REG_KV], ev2)),
              qmul(gains[ctc_pkg::REG_KP], e2));
    t1 = qadd(qadd(qmul(m11, sa), qmul(m12, sb)), n1);
    t2 = qadd(qadd(qmul(m12, sa), qmul(m22, sb)), n2);
    w.t1 = ctc_pkg::fx_t'(t1); w.t2 = ctc_pkg::fx_t'(t2);
    w.e1 = ctc_pkg::fx_t'(e1); w.e2 = ctc_pkg::fx_t'(e2);
    w.sat = clip_seen;
  endtask

  // acceptance, prediction and result checking
  always @(posedge clk) begin
    torque_word_t w, got;
    ctc_pkg::fx_t cur[10];
    if (!rst) begin
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (start && !busy) begin
        cur = '{a1m, a2m, s1m, s2m, a1t, a2t, s1t, s2t, c1t, c2t};
        torque_law(cur, w);
        pending_torques.insert(pending_torques.size(), w);
      end
      if (done) begin
        got = '{torque_joint1, torque_joint2, angle1_error, angle2_error, saturated};
        if (pending_torques.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word at %0t", $realtime);
        end else begin
          w = pending_torques.pop_front();
          if (got.t1 !== w.t1 || got.t2 !== w.t2 || got.e1 !== w.e1 ||
              got.e2 !== w.e2 || got.sat !== w.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"word mismatch: exp t1=%h t2=%h e1=%h e2=%h sat=%b ",
                        "got t1=%h t2=%h e1=%h e2=%h sat=%b"},
                       w.t1, w.t2, w.e1, w.e2, w.sat,
                       got.t1, got.t2, got.e1, got.e2, got.sat);
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic cfg_write(input ctc_pkg::reg_idx_t idx, input logic [30:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ctc_pkg::ADDR_W'(int'(idx) * 4); pwdata <= {1'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    gains[idx] = longint'(value);
  endtask

  task automatic settle;
    start <= 1'b0;
    while (pending_torques.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic load_gains(input logic [30:0] l1, l2, m1, m2, g, kp, kv);
    settle();
    cfg_write(ctc_pkg::REG_L1, l1); cfg_write(ctc_pkg::REG_L2, l2);
    cfg_write(ctc_pkg::REG_M1, m1); cfg_write(ctc_pkg::REG_M2, m2);
    cfg_write(ctc_pkg::REG_G, g); cfg_write(ctc_pkg::REG_KP, kp);
    cfg_write(ctc_pkg::REG_KV, kv);
  endtask

  task automatic send_word(input ctc_pkg::fx_t v[10]);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    a1m <= v[0]; a2m <= v[1]; s1m <= v[2]; s2m <= v[3]; a1t <= v[4];
    a2t <= v[5]; s1t <= v[6]; s2t <= v[7]; c1t <= v[8]; c2t <= v[9];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic ctc_pkg::fx_t pick_field(int mode);
    case (mode)
      0: return ctc_pkg::fx_t'($urandom);
      1: return ctc_pkg::fx_t'($urandom_range(0, 2 * 524288) - 524288);
      2: return ctc_pkg::fx_t'($urandom_range(0, 2 * 65536) - 65536);
      default: return $urandom_range(0, 1) ? ctc_pkg::FX_MAX : ctc_pkg::FX_MIN;
    endcase
  endfunction

  task automatic random_burst(input int count);
    ctc_pkg::fx_t v[10];
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 9);
      for (int f = 0; f < 10; f++)
        v[f] = pick_field(mode < 3 ? 0 : mode < 7 ? 1 : mode < 9 ? 2 : $urandom_range(0, 3));
      send_word(v);
    end
  endtask

  initial begin
    ctc_pkg::fx_t v[10];
    gains = '{longint'(ctc_pkg::RST_L1), longint'(ctc_pkg::RST_L2),
              longint'(ctc_pkg::RST_M1), longint'(ctc_pkg::RST_M2),
              longint'(ctc_pkg::RST_G), longint'(ctc_pkg::RST_KP),
              longint'(ctc_pkg::RST_KV)};
    vectors.insert(vectors.size(), '{'{default: 32'sd0}, 1'b1, 32'sd0, 32'sd0});
    vectors.insert(vectors.size(), '{'{default: ctc_pkg::FX_MAX}, 1'b1, 32'sd0, 32'sd0});
    vectors.insert(vectors.size(), '{'{default: ctc_pkg::FX_MIN}, 1'b1, 32'sd0, 32'sd0});
    vectors.insert(vectors.size(),
      '{'{ctc_pkg::FX_MIN, ctc_pkg::FX_MIN, 0, 0, ctc_pkg::FX_MAX, ctc_pkg::FX_MAX,
          0, 0, 0, 0}, 1'b1, ctc_pkg::FX_MAX, ctc_pkg::FX_MAX});
    vectors.insert(vectors.size(),
      '{'{ctc_pkg::FX_MAX, ctc_pkg::FX_MAX, 0, 0, ctc_pkg::FX_MIN, ctc_pkg::FX_MIN,
          0, 0, 0, 0}, 1'b1, ctc_pkg::FX_MIN, ctc_pkg::FX_MIN});
    vectors.insert(vectors.size(),
      '{'{205887, -205887, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, 0, 0});
    vectors.insert(vectors.size(),
      '{'{-205887, 205887, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, 0, 0});
    vectors.insert(vectors.size(),
      '{'{102944, -102944, 65536, -65536, 0, 0, 0, 0, 0, 0}, 1'b0, 0, 0});
    vectors.insert(vectors.size(),
      '{'{-102944, 102944, 0, 0, 0, 0, 0, 0, 65536, -65536}, 1'b0, 0, 0});
    vectors.insert(vectors.size(),
      '{'{411774, 411775, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, 0, 0});
    vectors.insert(vectors.size(),
      '{'{ctc_pkg::FX_MAX, ctc_pkg::FX_MIN, ctc_pkg::FX_MAX, ctc_pkg::FX_MIN,
          0, 0, 0, 0, 0, 0}, 1'b0, 0, 0});
    vectors.insert(vectors.size(),
      '{'{0, 0, ctc_pkg::FX_MIN, ctc_pkg::FX_MAX, 0, 0, ctc_pkg::FX_MAX,
          ctc_pkg::FX_MIN, 0, 0}, 1'b0, 0, 0});
    vectors.insert(vectors.size(),
      '{'{0, 0, 0, 0, 0, 0, 0, 0, ctc_pkg::FX_MAX, ctc_pkg::FX_MIN}, 1'b0, 0, 0});
    vectors.insert(vectors.size(),
      '{'{65536, 131072, 32768, -32768, 98304, 65536, 0, 65536,
          -65536, 16384}, 1'b0, 0, 0});
    vectors.insert(vectors.size(),
      '{'{-1, 1, -1, 1, 1, -1, 1, -1, -1, 1}, 1'b0, 0, 0});
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (vectors[i]) begin
      send_word(vectors[i].v);
      if (vectors[i].chk) begin
        torque_word_t w;
        torque_law(vectors[i].v, w);
        if (w.e1 !== vectors[i].e1 || w.e2 !== vectors[i].e2) begin
          mismatches++;
          if (mismatches <= 10)
            $display("error row %0d: exp e1=%h e2=%h got e1=%h e2=%h", i,
                     vectors[i].e1, vectors[i].e2, w.e1, w.e2);
        end
      end
    end
    random_burst(150);
    load_gains('1, '1, '1, '1, '1, '1, '1);
    random_burst(100);
    load_gains('0, '0, '0, '0, '0, '0, '0);
    random_burst(100);
    load_gains(31'd65536, 31'd98304, 31'd131072, 31'd32768, 31'd642908,
               31'd1310720, 31'd327680);
    random_burst(200);
    load_gains(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom),
               31'($urandom), 31'($urandom), 31'($urandom));
    random_burst(100);
    load_gains(31'($urandom_range(0, 262144)), 31'($urandom_range(0, 262144)),
               31'($urandom_range(0, 262144)), 31'($urandom_range(0, 262144)),
               31'($urandom_range(0, 1048576)), 31'($urandom_range(0, 1048576)),
               31'($urandom_range(0, 1048576)));
    random_burst(200);
    settle();
    if (mismatches == 0 && pending_torques.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
